>>> src/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg: shared types, constants and rounding helpers
// Widths, the arctangent table and the fixed-point round/saturate functions
// used by the cordic cells and the matrix unit.
// ----------------------------------------------------------------------------
package erm_pkg;

    // configuration of the datapath
    localparam int ANGLE_BITS    = 16;
    localparam int FRACTION_BITS = 14;
    localparam int CORDIC_STAGES = 16;

    // field widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // cordic working format: 30 fraction bits, head room for gain overshoot
    localparam int WORK_FRAC = 30;
    localparam int XY_W      = WORK_FRAC + 3;
    localparam int NUM_CELLS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
    localparam int STAGE_W   = 5;
    localparam int NUM_AXES  = 3;

    // product and sum widths of the matrix arithmetic
    localparam int PROD_W = 2 * OUT_W;
    localparam int SUM_W  = PROD_W + 1;

    // pipeline depth from accepted transaction to result strobe
    localparam int LATENCY = NUM_CELLS + 3;

    // starting x: cordic gain compensation at 30 fraction bits
    localparam logic signed [XY_W-1:0] X_INIT = XY_W'(652032874);

    // rounding of the cordic outputs down to the result fraction
    localparam int TRIG_SHIFT = WORK_FRAC - FRACTION_BITS;
    localparam logic signed [XY_W-1:0] TRIG_HALF =
        (TRIG_SHIFT > 0) ? XY_W'(64'sd1 <<< (TRIG_SHIFT - 1)) : '0;
    localparam logic signed [XY_W-1:0] ONE_XY = XY_W'(64'sd1 <<< FRACTION_BITS);

    // rounding of products back to the result fraction
    localparam logic signed [SUM_W-1:0] PROD_HALF = SUM_W'(64'sd1 <<< (FRACTION_BITS - 1));
    localparam logic signed [SUM_W-1:0] ONE_SUM   = SUM_W'(64'sd1 <<< FRACTION_BITS);
    localparam logic signed [OUT_W-1:0] ONE_OUT   = OUT_W'(64'sd1 <<< FRACTION_BITS);

    // arctangent table, full turn = 2^32, rounded down
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81,
        32'd40,        32'd20,        32'd10,        32'd5,
        32'd2,         32'd1,         32'd0,         32'd0
    };

    // rotator state for one angle
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [XY_W-1:0] z;
        logic [1:0]             quad;
    } erm_rot_t;

    // what one cell hands to the next
    typedef struct packed {
        logic                        valid;
        erm_rot_t [NUM_AXES-1:0]     rot;
    } erm_cell_t;

    // the nine matrix elements
    typedef struct packed {
        logic signed [OUT_W-1:0] m00;
        logic signed [OUT_W-1:0] m01;
        logic signed [OUT_W-1:0] m02;
        logic signed [OUT_W-1:0] m10;
        logic signed [OUT_W-1:0] m11;
        logic signed [OUT_W-1:0] m12;
        logic signed [OUT_W-1:0] m20;
        logic signed [OUT_W-1:0] m21;
        logic signed [OUT_W-1:0] m22;
    } erm_mat_t;

    // round a cordic output to the result fraction and saturate to +-1.0
    function automatic logic signed [OUT_W-1:0] round_trig(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] t;
        t = (v + TRIG_HALF) >>> TRIG_SHIFT;
        if (t > ONE_XY)
            round_trig = ONE_OUT;
        else if (t < -ONE_XY)
            round_trig = -ONE_OUT;
        else
            round_trig = OUT_W'(t);
    endfunction

    // round a product sum to the result fraction and saturate to +-1.0
    function automatic logic signed [OUT_W-1:0] round_prod(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = (v + PROD_HALF) >>> FRACTION_BITS;
        if (t > ONE_SUM)
            round_prod = ONE_OUT;
        else if (t < -ONE_SUM)
            round_prod = -ONE_OUT;
        else
            round_prod = OUT_W'(t);
    endfunction

    // full-width signed product, extended to the sum width
    function automatic logic signed [SUM_W-1:0] mul(input logic signed [OUT_W-1:0] a,
                                                    input logic signed [OUT_W-1:0] b);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b);
        mul = SUM_W'(p);
    endfunction

endpackage

>>> src/erm_cordic_cell.sv
// ----------------------------------------------------------------------------
// erm_cordic_cell: one rotation step for all three angles
// Applies one cordic micro-rotation to each rotator and registers the result
// for the next cell in the row.
// ----------------------------------------------------------------------------
module erm_cordic_cell
    import erm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [STAGE_W-1:0]   stage,
    input  erm_cell_t            cell_in,
    output erm_cell_t            cell_out
);

    logic                        valid_reg;
    erm_rot_t [NUM_AXES-1:0]     rot_reg;
    erm_rot_t [NUM_AXES-1:0]     rot_next;
    logic signed [XY_W-1:0]      atan_val;

    assign atan_val = XY_W'(ATAN_TAB[stage]);

    // micro-rotation, direction from the sign of the remaining angle
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            rot_next[k].quad = cell_in.rot[k].quad;
            if (!cell_in.rot[k].z[XY_W-1])
            begin
                rot_next[k].x = cell_in.rot[k].x - (cell_in.rot[k].y >>> stage);
                rot_next[k].y = cell_in.rot[k].y + (cell_in.rot[k].x >>> stage);
                rot_next[k].z = cell_in.rot[k].z - atan_val;
            end
            else
            begin
                rot_next[k].x = cell_in.rot[k].x + (cell_in.rot[k].y >>> stage);
                rot_next[k].y = cell_in.rot[k].y - (cell_in.rot[k].x >>> stage);
                rot_next[k].z = cell_in.rot[k].z + atan_val;
            end
        end
    end

    // valid travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cell_in.valid;
    end

    // rotator payload
    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.rot   = rot_reg;

endmodule

>>> src/erm_matrix_unit.sv
// ----------------------------------------------------------------------------
// erm_matrix_unit: quadrant fold and matrix assembly
// Folds the cordic vectors into sine/cosine, then forms the nine elements of
// the Z*X*Y rotation matrix over two multiply stages.
// ----------------------------------------------------------------------------
module erm_matrix_unit
    import erm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  erm_cell_t  cell_in,
    output logic       done,
    output erm_mat_t   mat
);

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;

    // stage 1 registers: sine and cosine per axis (0 = x, 1 = y, 2 = z)
    logic                    v1_reg;
    logic signed [OUT_W-1:0] cos_reg [NUM_AXES];
    logic signed [OUT_W-1:0] sin_reg [NUM_AXES];
    logic signed [OUT_W-1:0] cos_next [NUM_AXES];
    logic signed [OUT_W-1:0] sin_next [NUM_AXES];

    // stage 2 registers
    logic                    v2_reg;
    logic signed [OUT_W-1:0] bd_reg, bc_reg;
    logic signed [OUT_W-1:0] cb_reg, sb_reg, cc_reg, sc_reg;
    logic signed [OUT_W-1:0] m01_reg, m11_reg, m20_reg, m21_reg, m22_reg;

    // stage 3 registers
    logic                    v3_reg;
    erm_mat_t                mat_reg;
    erm_mat_t                mat_next;

    // quadrant fold, round and saturate
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            case (cell_in.rot[k].quad)
                QUAD_0:
                begin
                    cos_next[k] = round_trig(cell_in.rot[k].x);
                    sin_next[k] = round_trig(cell_in.rot[k].y);
                end
                QUAD_90:
                begin
                    cos_next[k] = round_trig(-cell_in.rot[k].y);
                    sin_next[k] = round_trig(cell_in.rot[k].x);
                end
                QUAD_180:
                begin
                    cos_next[k] = round_trig(-cell_in.rot[k].x);
                    sin_next[k] = round_trig(-cell_in.rot[k].y);
                end
                default:
                begin
                    cos_next[k] = round_trig(cell_in.rot[k].y);
                    sin_next[k] = round_trig(-cell_in.rot[k].x);
                end
            endcase
        end
    end

    // elements that need the sx*sy and sx*cy terms
    always_comb
    begin
        mat_next     = '0;
        mat_next.m00 = round_prod(mul(cc_reg, cb_reg) + mul(sc_reg, bd_reg));
        mat_next.m02 = round_prod(mul(sc_reg, bc_reg) - mul(cc_reg, sb_reg));
        mat_next.m10 = round_prod(mul(cc_reg, bd_reg) - mul(sc_reg, cb_reg));
        mat_next.m12 = round_prod(mul(sc_reg, sb_reg) + mul(cc_reg, bc_reg));
        mat_next.m01 = m01_reg;
        mat_next.m11 = m11_reg;
        mat_next.m20 = m20_reg;
        mat_next.m21 = m21_reg;
        mat_next.m22 = m22_reg;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cell_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            cos_reg[k] <= cos_next[k];
            sin_reg[k] <= sin_next[k];
        end
        // single products, the negated x sine and pass-through of the y and z terms
        bd_reg  <= round_prod(mul(sin_reg[0], sin_reg[1]));
        bc_reg  <= round_prod(mul(sin_reg[0], cos_reg[1]));
        m01_reg <= round_prod(mul(cos_reg[0], sin_reg[2]));
        m11_reg <= round_prod(mul(cos_reg[0], cos_reg[2]));
        m20_reg <= round_prod(mul(cos_reg[0], sin_reg[1]));
        m22_reg <= round_prod(mul(cos_reg[0], cos_reg[1]));
        m21_reg <= -sin_reg[0];
        cb_reg  <= cos_reg[1];
        sb_reg  <= sin_reg[1];
        cc_reg  <= cos_reg[2];
        sc_reg  <= sin_reg[2];
        mat_reg <= mat_next;
    end

    assign done = v3_reg;
    assign mat  = mat_reg;

endmodule

>>> src/euler_angles_to_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top: Z*X*Y rotation matrix from angles
// Binary angles about X, Y and Z in; nine Q1.14 matrix elements out.
// ----------------------------------------------------------------------------
// Usage:
//   Drive angle_x, angle_y, angle_z (65536 = one turn) with start high for
//   one cycle per transaction. busy is always low: a new transaction may be
//   started in every cycle, whatever is still in flight.
//   Each transaction gives one result: done is high for exactly one cycle,
//   with m00..m22 valid in that cycle. Results leave in the order taken.
//   Throughput is one transaction per cycle. The pipeline is the row of 16
//   cordic cells (one micro-rotation each, all three angles side by side),
//   one quadrant-fold stage and two multiply stages.
//   The receiver cannot stall; results are never held back.
//   Reset (rst_n low, asynchronous) clears every valid bit in the pipeline,
//   so transactions in flight are dropped and no done follows.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_top
    import erm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [IN_W-1:0]         angle_x,
    input  logic [IN_W-1:0]         angle_y,
    input  logic [IN_W-1:0]         angle_z,
    output logic                    done,
    output logic signed [OUT_W-1:0] m00,
    output logic signed [OUT_W-1:0] m01,
    output logic signed [OUT_W-1:0] m02,
    output logic signed [OUT_W-1:0] m10,
    output logic signed [OUT_W-1:0] m11,
    output logic signed [OUT_W-1:0] m12,
    output logic signed [OUT_W-1:0] m20,
    output logic signed [OUT_W-1:0] m21,
    output logic signed [OUT_W-1:0] m22
);

    erm_cell_t        chain [NUM_CELLS+1];
    logic [IN_W-1:0]  ang   [NUM_AXES];
    logic [31:0]      a32   [NUM_AXES];
    erm_mat_t         mat;

    assign busy   = 1'b0;
    assign ang[0] = angle_x;
    assign ang[1] = angle_y;
    assign ang[2] = angle_z;

    // scale to a 32-bit turn, split into quadrant and residual
    always_comb
    begin
        chain[0].valid = start;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            a32[k] = 32'(ang[k][ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
            chain[0].rot[k].quad = a32[k][31:30];
            chain[0].rot[k].x    = X_INIT;
            chain[0].rot[k].y    = '0;
            chain[0].rot[k].z    = XY_W'(a32[k][29:0]);
        end
    end

    // row of cordic cells
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        erm_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage    (STAGE_W'(i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // sine/cosine fold and matrix assembly
    erm_matrix_unit u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_in (chain[NUM_CELLS]),
        .done    (done),
        .mat     (mat)
    );

    assign m00 = mat.m00;
    assign m01 = mat.m01;
    assign m02 = mat.m02;
    assign m10 = mat.m10;
    assign m11 = mat.m11;
    assign m12 = mat.m12;
    assign m20 = mat.m20;
    assign m21 = mat.m21;
    assign m22 = mat.m22;

    // every accepted transaction yields a result after the fixed latency
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("missing result for accepted transaction");

    // no result without a transaction accepted at the matching edge
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without accepted transaction");

    // the summed elements m00 and m12 stay within saturation limits
    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (m00 <= ONE_OUT) && (m00 >= -ONE_OUT) &&
                 (m12 <= ONE_OUT) && (m12 >= -ONE_OUT))
        else $error("matrix element out of range");

endmodule

>>> dv/erm_matrix_checker.sv
// ----------------------------------------------------------------------------
// erm_matrix_checker: scoreboard for the euler angle rotation matrix block
// Watches the start and done channels of the block, predicts the nine
// Q1.14 matrix elements of every accepted angle triple with its own
// cordic and product arithmetic, and compares each result in order.
// ----------------------------------------------------------------------------
module erm_matrix_checker
    import erm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [IN_W-1:0]         angle_x,
    input  logic [IN_W-1:0]         angle_y,
    input  logic [IN_W-1:0]         angle_z,
    input  logic                    done,
    input  logic signed [OUT_W-1:0] m00,
    input  logic signed [OUT_W-1:0] m01,
    input  logic signed [OUT_W-1:0] m02,
    input  logic signed [OUT_W-1:0] m10,
    input  logic signed [OUT_W-1:0] m11,
    input  logic signed [OUT_W-1:0] m12,
    input  logic signed [OUT_W-1:0] m20,
    input  logic signed [OUT_W-1:0] m21,
    input  logic signed [OUT_W-1:0] m22,
    output int                      n_pending,
    output int                      n_checked,
    output int                      n_errors
);

    // quadrant taken from the top two bits of the 32-bit angle
    typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} quadrant_t;

    localparam longint GAIN_X0    = 652032874;
    localparam longint UNIT       = 64'sd1 <<< FRACTION_BITS;

    // micro-rotation angles, 2^32 per turn, rounded down
    localparam longint ARCTAN [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20,
        10, 5, 2, 1, 0, 0
    };

    localparam string ELEM_NAME [0:8] = '{
        "m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"
    };

    // expected matrices in the order their transactions were taken
    erm_mat_t pending_matrices [$];

    // round half up by sh bits, then clamp to +-1.0
    function automatic longint round_clamp(input longint v, input int sh);
        longint t;
        t = (sh == 0) ? v : ((v + (64'sd1 <<< (sh - 1))) >>> sh);
        if (t > UNIT)
            t = UNIT;
        else if (t < -UNIT)
            t = -UNIT;
        return t;
    endfunction

    // cosine and sine of one binary angle
    function automatic void sin_cos(input logic [IN_W-1:0] ang,
                                    output longint cos_v, output longint sin_v);
        logic [31:0] turn;
        quadrant_t   quad;
        longint      x, y, z, dx, dy, cv, sv;
        turn = 32'(ang) << (32 - ANGLE_BITS);
        quad = quadrant_t'(turn[31:30]);
        z    = longint'(turn[29:0]);
        x    = GAIN_X0;
        y    = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
        // fold the residual vector back into its quadrant
        case (quad)
            Q_FIRST:  begin cv = x;  sv = y;  end
            Q_SECOND: begin cv = -y; sv = x;  end
            Q_THIRD:  begin cv = -x; sv = -y; end
            default:  begin cv = y;  sv = -x; end
        endcase
        cos_v = round_clamp(cv, WORK_FRAC - FRACTION_BITS);
        sin_v = round_clamp(sv, WORK_FRAC - FRACTION_BITS);
    endfunction

    // left-handed Rz * Rx * Ry for one angle triple
    function automatic erm_mat_t rotation_of(input logic [IN_W-1:0] ax,
                                             input logic [IN_W-1:0] ay,
                                             input logic [IN_W-1:0] az);
        longint   cx, sx, cy, sy, cz, sz, sxsy, sxcy;
        erm_mat_t m;
        sin_cos(ax, cx, sx);
        sin_cos(ay, cy, sy);
        sin_cos(az, cz, sz);
        sxsy  = round_clamp(sx * sy, FRACTION_BITS);
        sxcy  = round_clamp(sx * cy, FRACTION_BITS);
        m.m00 = OUT_W'(round_clamp(cz * cy + sz * sxsy, FRACTION_BITS));
        m.m01 = OUT_W'(round_clamp(cx * sz, FRACTION_BITS));
        m.m02 = OUT_W'(round_clamp(-(cz * sy) + sz * sxcy, FRACTION_BITS));
        m.m10 = OUT_W'(round_clamp(-(sz * cy) + cz * sxsy, FRACTION_BITS));
        m.m11 = OUT_W'(round_clamp(cx * cz, FRACTION_BITS));
        m.m12 = OUT_W'(round_clamp(sz * sy + cz * sxcy, FRACTION_BITS));
        m.m20 = OUT_W'(round_clamp(cx * sy, FRACTION_BITS));
        m.m21 = OUT_W'(-sx);
        m.m22 = OUT_W'(round_clamp(cx * cy, FRACTION_BITS));
        return m;
    endfunction

    // clear on reset, else compare results, then record new transactions
    always @(posedge clk)
    begin
        erm_mat_t                want;
        logic signed [OUT_W-1:0] want_e [0:8];
        logic signed [OUT_W-1:0] got_e  [0:8];
        if (!rst_n)
        begin
            pending_matrices.delete();
            n_pending = 0;
            n_checked = 0;
            n_errors  = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_matrices.size() == 0)
                begin
                    n_errors++;
                    $error("result strobe with no transaction outstanding");
                end
                else
                begin
                    want   = pending_matrices.pop_front();
                    want_e = '{want.m00, want.m01, want.m02, want.m10, want.m11,
                               want.m12, want.m20, want.m21, want.m22};
                    got_e  = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
                    n_checked++;
                    for (int k = 0; k < 9; k++)
                    begin
                        if (got_e[k] !== want_e[k])
                        begin
                            n_errors++;
                            $error("%s mismatch: expected %0d, actual %0d",
                                   ELEM_NAME[k], want_e[k], got_e[k]);
                        end
                    end
                end
            end
            if (start && !busy)
                pending_matrices.push_back(rotation_of(angle_x, angle_y, angle_z));
            n_pending = pending_matrices.size();
        end
    end

endmodule

>>> dv/euler_angles_to_rotation_matrix_top_tb.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top_tb: testbench top
// Drives angle triples into the rotation matrix block, first a directed set
// of quadrant edges and extremes, then random triples with idle bursts, and
// leaves prediction and comparison to the matrix checker.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix_top_tb;
    import erm_pkg::*;

    localparam int STALL_LIMIT  = 500;
    localparam int RANDOM_COUNT = 450;
    localparam int QUIET_TAIL   = 60;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [IN_W-1:0]         angle_x;
    logic [IN_W-1:0]         angle_y;
    logic [IN_W-1:0]         angle_z;
    logic                    done;
    logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    int n_pending;
    int n_checked;
    int n_errors;
    int n_directed;
    int n_random;
    int stall_cycles = 0;
    bit idle_on;

    euler_angles_to_rotation_matrix_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .angle_x (angle_x),
        .angle_y (angle_y),
        .angle_z (angle_z),
        .done    (done),
        .m00     (m00),
        .m01     (m01),
        .m02     (m02),
        .m10     (m10),
        .m11     (m11),
        .m12     (m12),
        .m20     (m20),
        .m21     (m21),
        .m22     (m22)
    );

    erm_matrix_checker matrix_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .done      (done),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22),
        .n_pending (n_pending),
        .n_checked (n_checked),
        .n_errors  (n_errors)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no transaction and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one transaction, then maybe an idle burst
    task automatic send_triple(input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                               input logic [IN_W-1:0] az);
        int gap;
        @(negedge clk);
        start   <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            start   <= 1'b0;
            angle_x <= IN_W'($urandom);
            angle_y <= IN_W'($urandom);
            angle_z <= IN_W'($urandom);
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    // random angle: uniform, near a quadrant edge, near an octant, or an extreme
    function automatic logic [IN_W-1:0] pick_angle();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
            return IN_W'($urandom);
        else if (kind <= 7)
            return IN_W'(($urandom_range(0, 3) << 14) + $urandom_range(0, 16) - 8);
        else if (kind == 8)
            return IN_W'(($urandom_range(0, 7) << 13) + $urandom_range(0, 64) - 32);
        else
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return '1;
                default: return IN_W'($urandom_range(0, 3) << 14);
            endcase
        end
    endfunction

    // stimulus and verdict
    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        angle_x    = '0;
        angle_y    = '0;
        angle_z    = '0;
        idle_on    = 1'b1;
        n_directed = 0;
        n_random   = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero, full scale, quadrant edges, octants
        send_triple(16'h0000, 16'h0000, 16'h0000);
        send_triple(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_triple(16'h4000, 16'h0000, 16'h0000);
        send_triple(16'h0000, 16'h4000, 16'h0000);
        send_triple(16'h0000, 16'h0000, 16'h4000);
        send_triple(16'h8000, 16'h8000, 16'h8000);
        send_triple(16'hC000, 16'hC000, 16'hC000);
        send_triple(16'h3FFF, 16'h7FFF, 16'hBFFF);
        send_triple(16'h4001, 16'h8001, 16'hC001);
        send_triple(16'h2000, 16'h2000, 16'h2000);
        send_triple(16'hE000, 16'h6000, 16'hA000);
        send_triple(16'h0001, 16'hFFFF, 16'h8000);
        send_triple(16'h5555, 16'hAAAA, 16'h0F0F);
        send_triple(16'h4000, 16'h4000, 16'h4000);
        send_triple(16'hC000, 16'h4000, 16'h8000);
        send_triple(16'h8000, 16'h0000, 16'h4000);
        send_triple(16'hFFFF, 16'h0000, 16'h0001);
        send_triple(16'h1234, 16'hEDCB, 16'h7F80);
        n_directed = 18;

        // random triples; the tail runs back to back
        for (int k = 0; k < RANDOM_COUNT; k++)
        begin
            idle_on = (k < RANDOM_COUNT - QUIET_TAIL);
            send_triple(pick_angle(), pick_angle(), pick_angle());
            n_random++;
        end
        @(negedge clk);
        start <= 1'b0;

        // drain, then watch a little longer for stray results
        while (n_pending != 0)
            @(negedge clk);
        repeat (LATENCY + 8)
            @(negedge clk);

        $display("drove %0d angle triples (%0d directed, %0d random), checked %0d matrices",
                 n_directed + n_random, n_directed, n_random, n_checked);
        if (n_errors == 0 && n_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
src/erm_pkg.sv
src/erm_cordic_cell.sv
src/erm_matrix_unit.sv
src/euler_angles_to_rotation_matrix_top.sv
dv/erm_matrix_checker.sv
dv/euler_angles_to_rotation_matrix_top_tb.sv
